[hw/rtl/avp_pkg.sv]
// avp_pkg: shared types, widths and codes for the average pooling block
// used by average_pooling_2d, avp_div and avp_checker; no dependencies
package avp_pkg;

  // default limits, handed to the top level as parameter defaults
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_POOL = 8;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_STRIDE  = 8;

  // configuration register widths
  localparam int PLANE_W  = 7;
  localparam int POOL_W   = 4;
  localparam int STRIDE_W = 4;
  localparam int PAD_W    = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // padded plane dimension (up to 127 + 2*7), cursor, window position
  localparam int DIM_W  = 8;
  localparam int CUR_W  = 8;
  localparam int Y_W    = 12;
  localparam int AREA_W = 8;

  localparam int ERR_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_SIZE     = 3'd5;

  // register reset values
  localparam logic [PLANE_W-1:0]  RST_PLANE_HEIGHT = 7'd8;
  localparam logic [PLANE_W-1:0]  RST_PLANE_WIDTH  = 7'd8;
  localparam logic [POOL_W-1:0]   RST_POOL_HEIGHT  = 4'd2;
  localparam logic [POOL_W-1:0]   RST_POOL_WIDTH   = 4'd2;
  localparam logic [STRIDE_W-1:0] RST_STRIDE_STEP  = 4'd2;
  localparam logic [PAD_W-1:0]    RST_PAD_SIZE     = 3'd0;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // result codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_WINDOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd2;

endpackage

[hw/rtl/avp_div.sv]
// avp_div: bit-serial restoring divider, one quotient bit per cycle
// depends on avp_pkg for the divisor width
module avp_div
  import avp_pkg::*;
#(
  parameter int DIVIDEND_W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [AREA_W-1:0]     divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [AREA_W-1:0]     rem;
  logic [CNT_W-1:0]      cnt;
  logic [AREA_W:0]       shifted;
  logic [AREA_W:0]       rem_next;
  logic                  fits;

  always_comb begin
    shifted  = {rem, quo[DIVIDEND_W-1]};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? (shifted - {1'b0, divisor}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        cnt <= CNT_W'(DIVIDEND_W);
      end else if (cnt != '0) begin
        quo <= {quo[DIVIDEND_W-2:0], fits};
        // remainder stays below the divisor
        rem <= rem_next[AREA_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[hw/rtl/average_pooling_2d.sv]
// average pooling over one zero-padded channel plane at a time
// load: a sample is written to the plane store while it has room. fetch: one plane
// store read per window cell, then a bit-serial divider (SUM_W = 24 at defaults)
// an error fetch skips the scan and divider; the input is not ready while a fetch runs
// reset (rst, synchronous) clears counters, cursor and handshakes and restores the register
// defaults; plane store contents are undefined until loaded
module average_pooling_2d
  import avp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_POOL = DEF_MAX_POOL
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [15:0] sample
  input  logic [0:0]             s_axis_tuser,   // [0] kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_BITS-1:0] m_axis_tdata,   // [15:0] average
  output logic                   m_axis_tlast,
  output logic [ERR_W-1:0]       m_axis_tuser    // [1:0] error_code
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_POOL + 1);
  localparam int CALC_W = (Y_W + DIM_W > ADDR_W) ? (Y_W + DIM_W) : ADDR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_WAIT,
    ST_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [PLANE_W-1:0]  plane_height;
  logic [PLANE_W-1:0]  plane_width;
  logic [POOL_W-1:0]   pool_height;
  logic [POOL_W-1:0]   pool_width;
  logic [STRIDE_W-1:0] stride_step;
  logic [PAD_W-1:0]    pad_size;

  // plane state
  logic [CNT_W-1:0] loaded_count;
  logic [CUR_W-1:0] out_row;
  logic [CUR_W-1:0] out_col;
  logic             emit_phase;

  // window scan
  logic [Y_W-1:0]    row_base;
  logic [Y_W-1:0]    col_base;
  logic [POOL_W-1:0] m_cnt;
  logic [POOL_W-1:0] n_cnt;
  logic              cell_vld;
  logic              cell_in;
  logic signed [SUM_W-1:0] acc;

  // result staging
  logic [SAMPLE_BITS-1:0] res_avg;
  logic                   res_last;
  logic [ERR_W-1:0]       res_err;

  // plane store
  logic [SAMPLE_BITS-1:0] store [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   rd_en;
  logic                   load_we;

  // clamped geometry
  logic [DIM_W-1:0]    h, w, p, hp, wp, row_span, col_span;
  logic [POOL_W-1:0]   ph, pw;
  logic [STRIDE_W-1:0] st;
  logic [2*DIM_W-1:0]  size;
  logic [AREA_W-1:0]   area;
  logic                win_err, plane_full, room, ready_to_emit;
  logic [Y_W-1:0]      row_pos, col_pos;
  logic                row_over, row_last, col_last, fetch_last;

  logic [Y_W-1:0]    y, x;
  logic              in_plane;
  logic [CALC_W-1:0] addr_full;

  logic                   s_accept;
  logic                   div_start, div_done;
  logic [SUM_W-1:0]       div_mag, div_quo;
  logic [SAMPLE_BITS-1:0] quo_low;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height <= RST_PLANE_HEIGHT;
      plane_width  <= RST_PLANE_WIDTH;
      pool_height  <= RST_POOL_HEIGHT;
      pool_width   <= RST_POOL_WIDTH;
      stride_step  <= RST_STRIDE_STEP;
      pad_size     <= RST_PAD_SIZE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PLANE_HEIGHT: plane_height <= cfg_data[PLANE_W-1:0];
        REG_PLANE_WIDTH:  plane_width  <= cfg_data[PLANE_W-1:0];
        REG_POOL_HEIGHT:  pool_height  <= cfg_data[POOL_W-1:0];
        REG_POOL_WIDTH:   pool_width   <= cfg_data[POOL_W-1:0];
        REG_STRIDE_STEP:  stride_step  <= cfg_data[STRIDE_W-1:0];
        REG_PAD_SIZE:     pad_size     <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plane_height == '0) h = DIM_W'(1);
    else if (int'(plane_height) > MAX_ROWS) h = DIM_W'(MAX_ROWS);
    else h = DIM_W'(plane_height);

    if (plane_width == '0) w = DIM_W'(1);
    else if (int'(plane_width) > MAX_COLS) w = DIM_W'(MAX_COLS);
    else w = DIM_W'(plane_width);

    if (pool_height == '0) ph = POOL_W'(1);
    else if (int'(pool_height) > MAX_POOL) ph = POOL_W'(MAX_POOL);
    else ph = pool_height;

    if (pool_width == '0) pw = POOL_W'(1);
    else if (int'(pool_width) > MAX_POOL) pw = POOL_W'(MAX_POOL);
    else pw = pool_width;

    if (stride_step == '0) st = STRIDE_W'(1);
    else if (int'(stride_step) > MAX_STRIDE) st = STRIDE_W'(MAX_STRIDE);
    else st = stride_step;

    p  = DIM_W'(pad_size);
    hp = h + {p[DIM_W-2:0], 1'b0};
    wp = w + {p[DIM_W-2:0], 1'b0};
    row_span = hp - DIM_W'(ph);
    col_span = wp - DIM_W'(pw);

    size = (2*DIM_W)'(h) * (2*DIM_W)'(w);
    area = AREA_W'(ph) * AREA_W'(pw);

    win_err       = (DIM_W'(ph) > hp) || (DIM_W'(pw) > wp);
    plane_full    = int'(loaded_count) >= int'(size);
    room          = int'(loaded_count) < int'(size);
    ready_to_emit = emit_phase || plane_full;

    // cursor tests done on window positions, so no grid-size division
    row_pos    = Y_W'(out_row) * Y_W'(st);
    col_pos    = Y_W'(out_col) * Y_W'(st);
    row_over   = row_pos > Y_W'(row_span);
    row_last   = (row_pos + Y_W'(st)) > Y_W'(row_span);
    col_last   = (col_pos + Y_W'(st)) > Y_W'(col_span);
    fetch_last = (row_last && col_last) || row_over;
  end

  // current window cell and its store address
  always_comb begin
    y = row_base + Y_W'(m_cnt);
    x = col_base + Y_W'(n_cnt);
    in_plane = (y >= Y_W'(p)) && (x >= Y_W'(p))
          && ((y - Y_W'(p)) < Y_W'(h)) && ((x - Y_W'(p)) < Y_W'(w));
    addr_full = CALC_W'(y - Y_W'(p)) * CALC_W'(w) + CALC_W'(x - Y_W'(p));
    rd_addr = addr_full[ADDR_W-1:0];
  end

  assign rd_en   = (state == ST_SCAN) && in_plane;
  assign load_we = s_accept && (s_axis_tuser[0] == KIND_LOAD) && room;

  always_ff @(posedge clk) begin
    if (load_we) begin
      store[loaded_count[ADDR_W-1:0]] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  assign div_start = (state == ST_DIV);
  assign div_mag   = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
  assign quo_low   = div_quo[SAMPLE_BITS-1:0];

  avp_div #(
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (area),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loaded_count  <= '0;
      out_row       <= '0;
      out_col       <= '0;
      emit_phase    <= 1'b0;
      cell_vld      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      cell_vld <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // store data arrives in the cycle after the scan step that read it
      if (cell_vld && cell_in) begin
        acc <= acc + {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
      end

      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser[0] == KIND_LOAD) begin
              if (room) begin
                loaded_count <= loaded_count + 1'b1;
                if (int'(loaded_count) + 1 >= int'(size)) begin
                  emit_phase <= 1'b1;
                end
              end
            end else begin
              res_avg  <= '0;
              res_last <= 1'b0;
              if (win_err) begin
                res_err <= ERR_WINDOW;
                state   <= ST_FIN;
              end else if (!ready_to_emit) begin
                res_err <= ERR_EMPTY;
                state   <= ST_FIN;
              end else begin
                res_err  <= ERR_NONE;
                res_last <= fetch_last;
                row_base <= row_pos;
                col_base <= col_pos;
                m_cnt    <= '0;
                n_cnt    <= '0;
                acc      <= '0;
                state    <= ST_SCAN;
                if (fetch_last) begin
                  loaded_count <= '0;
                  out_row      <= '0;
                  out_col      <= '0;
                  emit_phase   <= 1'b0;
                end else begin
                  emit_phase <= 1'b1;
                  if (col_last) begin
                    out_col <= '0;
                    out_row <= out_row + 1'b1;
                  end else begin
                    out_col <= out_col + 1'b1;
                  end
                end
              end
            end
          end
        end
        ST_SCAN: begin
          cell_vld <= 1'b1;
          cell_in  <= in_plane;
          if (n_cnt == pw - 1'b1) begin
            n_cnt <= '0;
            if (m_cnt == ph - 1'b1) begin
              state <= ST_DRAIN;
            end else begin
              m_cnt <= m_cnt + 1'b1;
            end
          end else begin
            n_cnt <= n_cnt + 1'b1;
          end
        end
        ST_DRAIN: state <= ST_DIV;
        ST_DIV:   state <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            // truncation toward zero: divide the magnitude, then restore the sign
            res_avg <= acc[SUM_W-1] ? (SAMPLE_BITS'(0) - quo_low) : quo_low;
            state   <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_avg;
            m_axis_tlast  <= res_last;
            m_axis_tuser  <= res_err;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/avp_checker.sv]
// avp_checker: port-level assertions for average_pooling_2d, bound to the top level
// depends on avp_pkg for item kinds and result codes
module avp_checker
  import avp_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [0:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [SAMPLE_BITS-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic [ERR_W-1:0]       m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // error results carry a zero average and never close a plane
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ERR_NONE) |-> !m_axis_tlast && (m_axis_tdata == '0))
    else $error("error result with data or last set");

  // a fetch transfer leaves the input not ready, as the block is then busy with the fetch
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == KIND_FETCH) |=> !s_axis_tready)
    else $error("input ready right after a fetch");

  // a new result only comes out of a running fetch
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while idle");

endmodule

bind average_pooling_2d avp_checker u_avp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
